// File: hdl/fwcs_pkg.sv
// ----------------------------------------------------------------------------
// fwcs_pkg: shared types and constants of the flash write chunk splitter
// Holds the word layouts, register indexes, reset values and the size picker.
// ----------------------------------------------------------------------------
package fwcs_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int FIELD_W         = 24;   // start_offset and byte_count width
	localparam int ADDR_W          = 32;
	localparam int DATA_W          = 64;
	localparam int S_TDATA_W       = 56;
	localparam int M_TDATA_W       = 104;

	localparam logic [1:0]        MAX_SIZE_RST  = 2'd2;
	localparam logic [ADDR_W-1:0] BASE_ADDR_RST = 32'h0800_0000;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_MAX_SIZE  = 1'b0,
		REG_BASE_ADDR = 1'b1
	} reg_index_t;

	// program size codes
	typedef enum logic [1:0] {
		SIZE_BYTE  = 2'd0,
		SIZE_HALF  = 2'd1,
		SIZE_WORD  = 2'd2,
		SIZE_DWORD = 2'd3
	} size_code_t;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               first;
		logic [FIELD_W-1:0] start_offset;
		logic [FIELD_W-1:0] byte_count;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] program_address;
		logic [1:0]        size_code;
		logic [DATA_W-1:0] program_data;
		logic              last;
	} result_t;

	// Largest size not above the limit, aligned at the address and covered by
	// the remaining count; a single byte always fits.
	function automatic logic [1:0] pick_size(
		input logic [2:0]         addr_lo,
		input logic [FIELD_W-1:0] remaining,
		input logic [1:0]         max_code
	);
		logic [1:0] code;
		code = SIZE_BYTE;
		if (max_code == SIZE_DWORD && addr_lo == 3'd0 && remaining >= FIELD_W'(8))
			code = SIZE_DWORD;
		else if (max_code >= SIZE_WORD && addr_lo[1:0] == 2'd0 && remaining >= FIELD_W'(4))
			code = SIZE_WORD;
		else if (max_code >= SIZE_HALF && addr_lo[0] == 1'b0 && remaining >= FIELD_W'(2))
			code = SIZE_HALF;
		return code;
	endfunction

endpackage

// File: hdl/flash_write_chunk_splitter.sv
// ----------------------------------------------------------------------------
// flash_write_chunk_splitter: split a byte stream into aligned program commands
// Gathers request bytes into chunks of 1, 2, 4 or 8 bytes and issues one
// program command per chunk.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one word per cycle while s_tready is high: a data byte, and on the
//   word flagged by s_tuser (first) also the request's offset and byte count.
//   Master channel (m_*) gives one program command per completed chunk:
//   absolute address, size code and little-endian data; m_tlast marks the
//   command that finishes the request. Words with no request active are
//   dropped, as is the word of an empty request.
//   Configuration: write cfg_data to register cfg_index when cfg_we is high
//   (0 max size code, 1 flash base). Write only while the block is idle.
// Timing:
//   A word is registered at the input and the chunk stage works on it
//   combinationally; the result register takes a command when the chunk
//   stage advances on its last byte. Throughput is one word per cycle
//   unless m_* stalls; a single chunk stage sits between the registers.
// Reset:
//   Both registers empty, no request active, max size code 2 and flash base
//   0x0800_0000.
// Stalls:
//   While m_tready is low and a command waits, the chunk stage holds and the
//   input register fills, then s_tready drops; no word is lost.
// ----------------------------------------------------------------------------
module flash_write_chunk_splitter #(
	parameter int OFFSET_BITS = fwcs_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [fwcs_pkg::ADDR_W-1:0]     cfg_data,
	// request byte stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] data_byte, [31:8] start_offset, [55:32] byte_count
	input  logic [fwcs_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] first
	input  logic                            s_tuser,
	// program command stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] program_address, [33:32] size_code, [97:34] program_data, rest zero
	output logic [fwcs_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);

	logic [1:0]                  max_size_code_q;
	logic [fwcs_pkg::ADDR_W-1:0] base_addr_q;

	fwcs_pkg::item_t   in_item;
	fwcs_pkg::item_t   item_s1;
	fwcs_pkg::result_t res;
	fwcs_pkg::result_t res_q;
	logic              valid_s1;
	logic              advance;
	logic              res_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_code_q <= fwcs_pkg::MAX_SIZE_RST;
			base_addr_q     <= fwcs_pkg::BASE_ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fwcs_pkg::REG_MAX_SIZE:  max_size_code_q <= cfg_data[1:0];
				fwcs_pkg::REG_BASE_ADDR: base_addr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the incoming word
	assign in_item.data_byte    = s_tdata[7:0];
	assign in_item.start_offset = s_tdata[31:8];
	assign in_item.byte_count   = s_tdata[55:32];
	assign in_item.first        = s_tuser;

	// advance the chunk stage when it holds a word and the result slot is free or draining
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	fwcs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fwcs_chunk #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_chunk (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item_s1       (item_s1),
		.max_size_code (max_size_code_q),
		.base_addr     (base_addr_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	fwcs_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_q     (res_q)
	);

	// pack the command word; pad bits stay zero
	assign m_tdata = {6'b0, res_q.program_data, res_q.size_code, res_q.program_address};
	assign m_tlast = res_q.last;

endmodule

// File: hdl/fwcs_in_reg.sv
// ----------------------------------------------------------------------------
// fwcs_in_reg: input register stage
// Captures one word per cycle while ready, and holds it until the chunk stage advances.
// ----------------------------------------------------------------------------
module fwcs_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fwcs_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output fwcs_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: hdl/fwcs_chunk.sv
// ----------------------------------------------------------------------------
// fwcs_chunk: chunk gathering stage
// Tracks the request, picks each chunk's size and gathers its bytes.
// ----------------------------------------------------------------------------
module fwcs_chunk #(
	parameter int OFFSET_BITS = fwcs_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  fwcs_pkg::item_t               item_s1,
	input  logic [1:0]                    max_size_code,
	input  logic [fwcs_pkg::ADDR_W-1:0]   base_addr,
	output logic                          res_valid,
	output fwcs_pkg::result_t             res
);

	localparam int FW = fwcs_pkg::FIELD_W;
	localparam int AW = fwcs_pkg::ADDR_W;
	localparam int DW = fwcs_pkg::DATA_W;

	logic [OFFSET_BITS-1:0] cur_offset_q;
	logic [FW-1:0]          remaining_q;
	logic [1:0]             chunk_code_q;
	logic [2:0]             gathered_q;
	logic [DW-1:0]          chunk_data_q;

	logic [OFFSET_BITS+FW-1:0] start_ext;
	logic [OFFSET_BITS-1:0]    offset;
	logic [FW-1:0]             remaining;
	logic [2:0]                gathered;
	logic [DW-1:0]             data_old;
	logic [AW-1:0]             address;
	logic [1:0]                code;
	logic [DW-1:0]             data_new;
	logic [3:0]                pos;
	logic [3:0]                size;
	logic                      active;
	logic                      done;

	always_comb begin
		start_ext = {{OFFSET_BITS{1'b0}}, item_s1.start_offset};
		offset    = item_s1.first ? start_ext[OFFSET_BITS-1:0] : cur_offset_q;
		remaining = item_s1.first ? item_s1.byte_count : remaining_q;
		gathered  = item_s1.first ? 3'd0 : gathered_q;
		data_old  = item_s1.first ? '0 : chunk_data_q;
		active    = remaining != '0;
		address   = base_addr + AW'(offset);
		code      = (gathered == 3'd0) ?
			fwcs_pkg::pick_size(address[2:0], remaining, max_size_code) : chunk_code_q;
		data_new  = ((gathered == 3'd0) ? '0 : data_old) |
			(DW'(item_s1.data_byte) << {gathered, 3'b000});
		pos       = {1'b0, gathered} + 4'd1;
		size      = 4'd1 << code;
		done      = pos == size;
		res_valid = active && done;
		res.program_address = address;
		res.size_code       = code;
		res.program_data    = data_new;
		res.last            = remaining == FW'(size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_offset_q <= '0;
			remaining_q  <= '0;
			chunk_code_q <= fwcs_pkg::SIZE_BYTE;
			gathered_q   <= '0;
			chunk_data_q <= '0;
		end else if (advance) begin
			if (!active) begin
				cur_offset_q <= offset;
				remaining_q  <= remaining;
				gathered_q   <= gathered;
				chunk_data_q <= data_old;
			end else if (!done) begin
				cur_offset_q <= offset;
				remaining_q  <= remaining;
				chunk_code_q <= code;
				gathered_q   <= pos[2:0];
				chunk_data_q <= data_new;
			end else begin
				cur_offset_q <= offset + OFFSET_BITS'(size);
				remaining_q  <= remaining - FW'(size);
				chunk_code_q <= code;
				gathered_q   <= '0;
				chunk_data_q <= '0;
			end
		end
	end

endmodule

// File: hdl/fwcs_out_reg.sv
// ----------------------------------------------------------------------------
// fwcs_out_reg: result register
// Holds one program command until the receiver takes it.
// ----------------------------------------------------------------------------
module fwcs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fwcs_pkg::result_t res,
	output logic              out_valid,
	input  logic              out_ready,
	output fwcs_pkg::result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
